>>> hw/rtl/mph_pkg.sv
// ============================================================================
// mph_pkg
// Shared constants, the item type and helper functions for the path hash unit.
// ============================================================================
package mph_pkg;

    // murmur3 mixing constants
    localparam logic [31:0] MIX_C1      = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2      = 32'h1b873593;
    localparam logic [31:0] MIX_ADD     = 32'he6546b64;
    localparam logic [31:0] FMIX_M1     = 32'h85ebca6b;
    localparam logic [31:0] FMIX_M2     = 32'hc2b2ae35;
    localparam logic [13:0] CHECK_SCALE = 14'd10000;

    // byte counts
    localparam logic [2:0] NBYTES_ONE   = 3'd1;
    localparam logic [2:0] NBYTES_TWO   = 3'd2;
    localparam logic [2:0] NBYTES_THREE = 3'd3;
    localparam logic [2:0] NBYTES_FULL  = 3'd4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified word as it travels from front to back
    typedef struct packed {
        logic [31:0] key;        // scrambled block or tail
        logic [2:0]  nbytes;     // bytes counted for this word
        logic        first;
        logic        last;
        logic        full;       // mix as a full block
        logic [31:0] total_len;
        logic [7:0]  first_b;
        logic [7:0]  last_b;
    } mph_item_t;

    // keep only the valid tail bytes
    function automatic logic [31:0] mask_tail(input logic [31:0] word,
                                              input logic [2:0]  nbytes);
        logic [31:0] res;
        case (nbytes)
            NBYTES_ONE:   res = {24'd0, word[7:0]};
            NBYTES_TWO:   res = {16'd0, word[15:0]};
            NBYTES_THREE: res = {8'd0, word[23:0]};
            default:      res = word;
        endcase
        return res;
    endfunction

    // pick the final valid byte of a word
    function automatic logic [7:0] pick_last(input logic [31:0] word,
                                             input logic [2:0]  nbytes);
        logic [7:0] res;
        case (nbytes)
            NBYTES_ONE:   res = word[7:0];
            NBYTES_TWO:   res = word[15:8];
            NBYTES_THREE: res = word[23:16];
            default:      res = word[31:24];
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

endpackage

>>> hw/rtl/mph_front.sv
// ============================================================================
// mph_front
// Accepts input words, classifies them as block or tail, and scrambles the
// key over two multiplier stages before writing it into the queue.
// ============================================================================
module mph_front
    import mph_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_data_word,
    input  logic [2:0]       s_valid_bytes,
    input  logic             s_first,
    input  logic             s_last,
    input  logic [31:0]      s_total_length,
    output logic             push,
    output mph_item_t        push_item,
    input  logic             queue_full
);

    logic      a_valid_reg, a_valid_next;
    mph_item_t a_item_reg;
    logic      b_valid_reg, b_valid_next;
    mph_item_t b_item_reg, b_item_next;
    logic      a_move;
    logic      s_take;
    logic [2:0] nv;
    mph_item_t in_item;
    logic [31:0] k_rot;

    // stage b leaves into the queue, stage a into stage b
    assign push    = b_valid_reg && !queue_full;
    assign a_move  = a_valid_reg && (!b_valid_reg || push);
    assign s_ready = !a_valid_reg || a_move;
    assign s_take  = s_valid && s_ready;

    // classify the incoming word
    always_comb begin
        if (s_last && (s_valid_bytes == NBYTES_ONE || s_valid_bytes == NBYTES_TWO ||
                       s_valid_bytes == NBYTES_THREE)) begin
            nv = s_valid_bytes;
        end else begin
            nv = NBYTES_FULL;
        end
        in_item.key       = mask_tail(s_data_word, nv);
        in_item.nbytes    = nv;
        in_item.first     = s_first;
        in_item.last      = s_last;
        in_item.full      = (nv == NBYTES_FULL);
        in_item.total_len = s_total_length;
        in_item.first_b   = s_data_word[7:0];
        in_item.last_b    = pick_last(s_data_word, nv);
    end

    // first scramble multiply on the way into stage b
    always_comb begin
        b_item_next     = a_item_reg;
        b_item_next.key = a_item_reg.key * MIX_C1;
    end

    // second scramble multiply lands in the queue register
    assign k_rot = rotl15(b_item_reg.key);
    always_comb begin
        push_item     = b_item_reg;
        push_item.key = k_rot * MIX_C2;
    end

    // valid bits
    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_take) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (push) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload: input register, then first scramble multiply
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_item_reg <= in_item;
        end
        if (a_move) begin
            b_item_reg <= b_item_next;
        end
    end

endmodule

>>> hw/rtl/mph_queue.sv
// ============================================================================
// mph_queue
// Short first-in first-out queue of classified words between front and back.
// ============================================================================
module mph_queue
    import mph_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  mph_item_t push_item,
    input  logic      pop,
    output mph_item_t head_item,
    output logic      empty,
    output logic      full
);

    mph_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/mph_back.sv
// ============================================================================
// mph_back
// Runs the recurrent hash update per word and, on the last word, the
// fmix finalizer and check value through a stallable pipeline.
// ============================================================================
module mph_back
    import mph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mph_item_t   head_item,
    input  logic        empty,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash,
    output logic [31:0] m_check,
    output logic        m_length_error
);

    // string state
    logic [31:0] h_reg, h_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [7:0]  fb_reg, fb_next;

    // finalizer stages
    logic        f1_valid_reg, f1_valid_next;
    logic [31:0] f1_h_reg, f1_len_reg;
    logic        f1_err_reg;
    logic [7:0]  f1_lb_reg, f1_fb_reg;

    logic        f2_valid_reg, f2_valid_next;
    logic [31:0] f2_p_reg, f2_check_reg;
    logic        f2_err_reg;

    logic        f3_valid_reg, f3_valid_next;
    logic [31:0] f3_q_reg, f3_check_reg;
    logic        f3_err_reg;

    logic        o_valid_reg, o_valid_next;
    logic [31:0] o_hash_reg, o_check_reg;
    logic        o_err_reg;

    logic        o_load, f3_move, f2_move, f1_move, f1_free;
    logic [31:0] h0, len0, cnt0, hx, hn;
    logic [7:0]  fb0;
    logic [31:0] y, z;
    logic [31:0] check_val;

    // stall chain from the output register back to the queue
    assign o_load  = f3_valid_reg && (!o_valid_reg || m_ready);
    assign f3_move = o_load;
    assign f2_move = f2_valid_reg && (!f3_valid_reg || f3_move);
    assign f1_move = f1_valid_reg && (!f2_valid_reg || f2_move);
    assign f1_free = !f1_valid_reg || f1_move;
    assign pop     = !empty && (!head_item.last || f1_free);

    // recurrent hash update
    always_comb begin
        h0   = head_item.first ? head_item.total_len : h_reg;
        len0 = head_item.first ? head_item.total_len : len_reg;
        cnt0 = head_item.first ? 32'd0 : cnt_reg;
        fb0  = head_item.first ? head_item.first_b : fb_reg;
        hx   = rotl13(h0 ^ head_item.key);
        if (head_item.full) begin
            hn = {hx[29:0], 2'b00} + hx + MIX_ADD;
        end else begin
            hn = h0 ^ head_item.key;
        end
        h_next   = h_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        fb_next  = fb_reg;
        if (pop) begin
            h_next   = hn;
            len_next = len0;
            cnt_next = cnt0 + {29'd0, head_item.nbytes};
            fb_next  = fb0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg   <= '0;
            len_reg <= '0;
            cnt_reg <= '0;
            fb_reg  <= '0;
        end else begin
            h_reg   <= h_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            fb_reg  <= fb_next;
        end
    end

    // finalizer arithmetic between stages
    assign y = f1_h_reg ^ f1_len_reg ^ {16'd0, f1_h_reg[31:16] ^ f1_len_reg[31:16]};
    assign z = f2_p_reg ^ {13'd0, f2_p_reg[31:13]};
    assign check_val = {{24{f1_lb_reg[7]}}, f1_lb_reg}
                     + ({{24{f1_fb_reg[7]}}, f1_fb_reg} * {18'd0, CHECK_SCALE});

    // pipeline valid bits
    always_comb begin
        f1_valid_next = f1_valid_reg;
        if (pop && head_item.last) begin
            f1_valid_next = 1'b1;
        end else if (f1_move) begin
            f1_valid_next = 1'b0;
        end
        f2_valid_next = f2_valid_reg;
        if (f1_move) begin
            f2_valid_next = 1'b1;
        end else if (f2_move) begin
            f2_valid_next = 1'b0;
        end
        f3_valid_next = f3_valid_reg;
        if (f2_move) begin
            f3_valid_next = 1'b1;
        end else if (f3_move) begin
            f3_valid_next = 1'b0;
        end
        o_valid_next = o_valid_reg;
        if (o_load) begin
            o_valid_next = 1'b1;
        end else if (m_ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
            f3_valid_reg <= f3_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // finalizer payload
    always_ff @(posedge aclk) begin
        if (pop && head_item.last) begin
            f1_h_reg   <= hn;
            f1_len_reg <= len0;
            f1_err_reg <= (cnt0 + {29'd0, head_item.nbytes}) != len0;
            f1_lb_reg  <= head_item.last_b;
            f1_fb_reg  <= fb0;
        end
        if (f1_move) begin
            f2_p_reg     <= y * FMIX_M1;
            f2_check_reg <= check_val;
            f2_err_reg   <= f1_err_reg;
        end
        if (f2_move) begin
            f3_q_reg     <= z * FMIX_M2;
            f3_check_reg <= f2_check_reg;
            f3_err_reg   <= f2_err_reg;
        end
        if (o_load) begin
            o_hash_reg  <= f3_q_reg ^ {16'd0, f3_q_reg[31:16]};
            o_check_reg <= f3_check_reg;
            o_err_reg   <= f3_err_reg;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_hash         = o_hash_reg;
    assign m_check        = o_check_reg;
    assign m_length_error = o_err_reg;

endmodule

>>> hw/rtl/murmur3_path_hash_unit.sv
// ============================================================================
// murmur3_path_hash_unit
// Streaming 32-bit murmur3 hash of a byte string with length seed and check.
// ============================================================================
// Input channel (s_valid / s_ready): one beat per little-endian 32-bit word.
// s_first opens a string and samples s_total_length; s_last closes it, and
// s_valid_bytes then gives how many bytes of that word count.
// Result channel (m_valid / m_ready): one beat per string, on its last word,
// carrying the finalized hash, the signed-byte check value and the length
// mismatch flag.
// Throughput: one word per cycle while s_ready is high; the back end's hash
// update is a combinational rotate, xor, times-five add on the running hash.
// Path from the last word's beat to m_valid with an empty queue: input
// register, key multiply, queue, hash update, two fmix multiply stages,
// output register.
// Reset: pipelines and queue empty, hash state, length, count and first
// byte cleared to zero; s_ready is high right after reset.
// Receiver stall: results hold in the output register and finalizer stages,
// then the four-entry queue fills and s_ready drops only when all are full.
// ============================================================================
module murmur3_path_hash_unit
    import mph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [31:0] s_total_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash,
    output logic [31:0] m_check,
    output logic        m_length_error
);

    logic      push, pop, queue_full, queue_empty;
    mph_item_t push_item, head_item;

    // classify and scramble
    mph_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_valid_bytes  (s_valid_bytes),
        .s_first        (s_first),
        .s_last         (s_last),
        .s_total_length (s_total_length),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    // decoupling queue
    mph_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // hash update and finalize
    mph_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_item      (head_item),
        .empty          (queue_empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash         (m_hash),
        .m_check        (m_check),
        .m_length_error (m_length_error)
    );

endmodule

>>> dv/murmur3_path_hash_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// murmur3_path_hash_unit_tb
// Self-checking bench for the streaming murmur3 path hash unit. A queue of
// words is built up front: a directed set of corner strings first, then
// random strings, mostly well formed, with some length mismatches, missing
// first markers and stray words. A clocked driver offers the words and a
// clocked monitor takes results. On every accepted word, a bit-accurate
// model of the hash pipeline predicts the hash, check and length flag, and
// the monitor compares each result beat with the oldest prediction. Idle
// rates change in three phases, and one long receiver stall backs the unit
// up until it stops taking input.
// ============================================================================
module murmur3_path_hash_unit_tb;
    import mph_pkg::*;

    // murmur3 constants
    localparam logic [31:0] K_SCRAMBLE1 = 32'hcc9e2d51;
    localparam logic [31:0] K_SCRAMBLE2 = 32'h1b873593;
    localparam logic [31:0] K_BLOCK_ADD = 32'he6546b64;
    localparam logic [31:0] K_AVAL1     = 32'h85ebca6b;
    localparam logic [31:0] K_AVAL2     = 32'hc2b2ae35;
    localparam logic [31:0] K_CHECK     = 32'd10000;

    localparam int N_WORDS       = 600;
    localparam int PHASE1_START  = 200;
    localparam int PHASE2_START  = 400;
    localparam int HOLD_AT_WORD  = 450;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        first;
        logic        last;
        logic [31:0] total_length;
    } word_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] check;
        logic        length_error;
    } digest_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic [2:0]  s_valid_bytes = '0;
    logic        s_first = 1'b0;
    logic        s_last = 1'b0;
    logic [31:0] s_total_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_hash;
    logic [31:0] m_check;
    logic        m_length_error;

    word_t   word_q[$];
    digest_t digest_q[$];

    // model of the unit's hash state
    logic [31:0] mh_state;
    logic [31:0] mh_length;
    logic [31:0] mh_count;
    logic [7:0]  mh_first_b;

    int words_in = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit stall_seen = 1'b0;
    int n_errors = 0;
    int n_digests = 0;
    int n_len_flags = 0;
    int n_queued = 0;

    murmur3_path_hash_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .s_valid_bytes  (s_valid_bytes),
        .s_first        (s_first),
        .s_last         (s_last),
        .s_total_length (s_total_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash         (m_hash),
        .m_check        (m_check),
        .m_length_error (m_length_error)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble(input logic [31:0] k);
        return rotl(k * K_SCRAMBLE1, 15) * K_SCRAMBLE2;
    endfunction

    function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
        return rotl(h ^ scramble(k), 13) * 32'd5 + K_BLOCK_ADD;
    endfunction

    function automatic logic [31:0] sext_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // idle percentages per phase, keyed on accepted words
    function automatic int send_gap_pct(input int n);
        if (n < PHASE1_START) return 8;
        if (n < PHASE2_START) return 75;
        return 0;
    endfunction

    function automatic int recv_gap_pct(input int n);
        if (n < PHASE1_START) return 75;
        if (n < PHASE2_START) return 8;
        return 0;
    endfunction

    // update the hash state with one accepted word, predict a digest on last
    task automatic absorb_word(input logic [31:0] word, input logic [2:0] cnt,
                               input logic first, input logic last,
                               input logic [31:0] tlen);
        logic [31:0] h;
        logic [7:0]  last_b;
        int          nb;
        digest_t     d;
        if (first) begin
            mh_length  = tlen;
            mh_state   = tlen;
            mh_count   = '0;
            mh_first_b = word[7:0];
        end
        if (!last) begin
            mh_state = mix_block(mh_state, word);
            mh_count = mh_count + 32'd4;
        end else begin
            nb = (cnt >= NBYTES_ONE && cnt <= NBYTES_FULL) ? int'(cnt) : 4;
            if (nb == 4)
                h = mix_block(mh_state, word);
            else
                h = mh_state ^ scramble(word & ((32'h1 << (8 * nb)) - 32'h1));
            mh_count = mh_count + nb;
            mh_state = h;
            last_b = 8'(word >> (8 * (nb - 1)));
            // fmix avalanche
            h = h ^ mh_length;
            h = h ^ (h >> 16);
            h = h * K_AVAL1;
            h = h ^ (h >> 13);
            h = h * K_AVAL2;
            h = h ^ (h >> 16);
            d.hash = h;
            d.check = sext_byte(last_b) + K_CHECK * sext_byte(mh_first_b);
            d.length_error = (mh_count != mh_length);
            digest_q.push_back(d);
        end
    endtask

    task automatic push_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic first, input logic last,
                             input logic [31:0] tlen);
        word_t w;
        w.data_word = data;
        w.valid_bytes = cnt;
        w.first = first;
        w.last = last;
        w.total_length = tlen;
        word_q.push_back(w);
        n_queued++;
    endtask

    // random data with a bias toward sign-boundary bytes
    function automatic logic [31:0] rand_data();
        logic [31:0] w;
        logic [7:0]  edges[4];
        edges = '{8'h00, 8'h7f, 8'h80, 8'hff};
        w = $urandom;
        if ($urandom_range(3) == 0) begin
            for (int i = 0; i < 4; i++)
                if ($urandom_range(1)) w[8*i +: 8] = edges[$urandom_range(3)];
        end
        return w;
    endfunction

    // one string of nbytes; odd_cnt puts an out-of-range count on a full last word
    task automatic queue_string(input int nbytes, input logic [31:0] decl,
                                input bit with_first, input bit odd_cnt);
        int          nw;
        logic [2:0]  cnt;
        logic        is_last;
        logic        is_first;
        nw = (nbytes + 3) / 4;
        for (int i = 0; i < nw; i++) begin
            is_last = (i == nw - 1);
            is_first = with_first && (i == 0);
            if (is_last) begin
                cnt = 3'(nbytes - 4 * (nw - 1));
                // 5..8 wraps to 5, 6, 7 or 0 in three bits
                if (cnt == NBYTES_FULL && odd_cnt) cnt = 3'($urandom_range(5, 8));
            end else begin
                cnt = 3'($urandom_range(7));
            end
            push_word(rand_data(), cnt, is_first, is_last,
                      is_first ? decl : 32'($urandom));
        end
    endtask

    // stimulus
    initial begin
        int r;
        int nbytes;
        logic [31:0] decl;
        // stray last word straight after reset
        push_word(32'h1234_5678, NBYTES_FULL, 1'b0, 1'b1, 32'hffff_ffff);
        // one-word strings at each byte count
        push_word(32'h0000_0080, NBYTES_ONE,   1'b1, 1'b1, 32'd1);
        push_word(32'hffff_ffff, NBYTES_FULL,  1'b1, 1'b1, 32'd4);
        push_word(32'h0000_7f80, NBYTES_TWO,   1'b1, 1'b1, 32'd2);
        push_word(32'h0080_ff7f, NBYTES_THREE, 1'b1, 1'b1, 32'd3);
        // declared lengths of zero and of all ones
        push_word(32'h0000_0000, NBYTES_ONE,   1'b1, 1'b1, 32'd0);
        push_word(32'h8000_00ff, NBYTES_FULL,  1'b1, 1'b1, 32'hffff_ffff);
        // three words, junk counts on the first two words
        push_word(32'hdead_beef, 3'b000,     1'b1, 1'b0, 32'd9);
        push_word(32'h0123_4567, 3'b111,     1'b0, 1'b0, 32'h0);
        push_word(32'h0000_00a5, NBYTES_ONE, 1'b0, 1'b1, 32'hffff_ffff);
        // out-of-range counts on the last word act as four
        push_word(32'h7f7f_7f7f, 3'b000, 1'b1, 1'b1, 32'd4);
        push_word(32'ha5a5_a5a5, 3'b101, 1'b1, 1'b1, 32'd4);
        push_word(32'h0102_0304, 3'b111, 1'b1, 1'b1, 32'd5);
        // words without first after a finished string
        push_word(32'h5555_aaaa, 3'b110,     1'b0, 1'b0, 32'h0);
        push_word(32'haaaa_5555, NBYTES_TWO, 1'b0, 1'b1, 32'h0);
        // full last word, empty tail
        push_word(32'h0f0f_0f0f, NBYTES_FULL, 1'b1, 1'b0, 32'd12);
        push_word(32'hf0f0_f0f0, NBYTES_FULL, 1'b0, 1'b0, 32'd0);
        push_word(32'h8080_8080, NBYTES_FULL, 1'b0, 1'b1, 32'd0);
        // first seen twice in one string
        push_word(32'h1111_1111, NBYTES_FULL, 1'b1, 1'b0, 32'd8);
        push_word(32'h2222_2222, NBYTES_FULL, 1'b1, 1'b0, 32'd8);
        push_word(32'h3333_3333, NBYTES_FULL, 1'b0, 1'b1, 32'd0);
        // more bytes than declared
        push_word(32'hff00_ff00, NBYTES_FULL, 1'b1, 1'b1, 32'd3);

        // random strings
        while (n_queued < N_WORDS) begin
            r = $urandom_range(99);
            nbytes = ($urandom_range(99) < 70) ? $urandom_range(1, 12) :
                     ($urandom_range(9) < 9) ? $urandom_range(13, 40) :
                     $urandom_range(41, 100);
            if (r < 80) begin
                queue_string(nbytes, 32'(nbytes), 1'b1, $urandom_range(9) == 0);
            end else if (r < 90) begin
                case ($urandom_range(3))
                    0: decl = 32'h0;
                    1: decl = 32'(nbytes + 1);
                    2: decl = 32'(nbytes - 1);
                    default: decl = $urandom;
                endcase
                queue_string(nbytes, decl, 1'b1, 1'b0);
            end else if (r < 95) begin
                queue_string($urandom_range(1, 8), 32'h0, 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3))
                    push_word(rand_data(), 3'($urandom_range(7)), 1'($urandom_range(1)),
                              1'b0, $urandom);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the queue and the unit to drain
        @(negedge aclk);
        while (word_q.size() > 0 || s_valid) @(negedge aclk);
        while (digest_q.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run: %0d words in, %0d digests checked, %0d with length mismatch",
                 words_in, n_digests, n_len_flags);
        $display("run: three idle phases, input stalled under long receiver hold: %0s",
                 stall_seen ? "yes" : "no");
        if (n_errors == 0)
            $display("** murmur3_path_hash_unit: PASSED **");
        else
            $display("** murmur3_path_hash_unit: FAILED **");
        $finish;
    end

    // word driver
    always @(posedge aclk) begin : drive
        word_t nxt;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            mh_state   = '0;
            mh_length  = '0;
            mh_count   = '0;
            mh_first_b = '0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_word(s_data_word, s_valid_bytes, s_first, s_last, s_total_length);
                words_in <= words_in + 1;
            end
            if (s_valid && !s_ready && hold_left > 0)
                stall_seen <= 1'b1;
            if (!s_valid || s_ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_gap_pct(words_in)) begin
                    nxt = word_q.pop_front();
                    s_valid        <= 1'b1;
                    s_data_word    <= nxt.data_word;
                    s_valid_bytes  <= nxt.valid_bytes;
                    s_first        <= nxt.first;
                    s_last         <= nxt.last;
                    s_total_length <= nxt.total_length;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : collect
        digest_t exp_d;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("result beat with no digest expected: hash %h", m_hash);
                    n_errors++;
                end else begin
                    exp_d = digest_q.pop_front();
                    n_digests++;
                    if (m_length_error) n_len_flags++;
                    if (m_hash !== exp_d.hash) begin
                        $error("hash mismatch: expected %h, actual %h", exp_d.hash, m_hash);
                        n_errors++;
                    end
                    if (m_check !== exp_d.check) begin
                        $error("check mismatch: expected %h, actual %h",
                               exp_d.check, m_check);
                        n_errors++;
                    end
                    if (m_length_error !== exp_d.length_error) begin
                        $error("length_error mismatch: expected %b, actual %b",
                               exp_d.length_error, m_length_error);
                        n_errors++;
                    end
                end
            end
            // one long hold so the unit backs up into its input
            if (!hold_done && words_in >= HOLD_AT_WORD) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_gap_pct(words_in));
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("** murmur3_path_hash_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mph_pkg.sv
hw/rtl/mph_front.sv
hw/rtl/mph_queue.sv
hw/rtl/mph_back.sv
hw/rtl/murmur3_path_hash_unit.sv
dv/murmur3_path_hash_unit_tb.sv
